[rtl/pla_pkg.sv]
// Package for the polyline length accumulator: shared constants and types.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package pla_pkg;

  // Fixed field widths of the channels.
  localparam int IN_COORD_W = 32;
  localparam int OUT_LEN_W  = 48;

  // Defaults for the top-level parameters.
  localparam int COORD_WIDTH_DEF = 32;
  localparam int ACC_WIDTH_DEF   = 48;

  // Entries in the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Control part of a job handed from front to back.
  typedef struct packed {
    logic has_seg;  // a previous point exists, so a segment is to be measured
    logic last;     // route ends with this point
  } pla_job_ctrl_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SQR,
    BK_SUM,
    BK_ROOT,
    BK_ACC
  } pla_bk_state_t;

endpackage

[rtl/pla_if.sv]
// Valid/ready channel interfaces for route points and route results.
// Depends on pla_pkg for the field widths.
interface pla_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [pla_pkg::IN_COORD_W-1:0] longitude;
  logic signed [pla_pkg::IN_COORD_W-1:0] latitude;
  logic                               last_point;

  modport source (output valid, longitude, latitude, last_point, input ready);
  modport sink   (input valid, longitude, latitude, last_point, output ready);
endinterface

interface pla_out_if;
  logic                           valid;
  logic                           ready;
  logic [pla_pkg::OUT_LEN_W-1:0]  route_length;
  logic                           length_saturated;

  modport source (output valid, route_length, length_saturated, input ready);
  modport sink   (input valid, route_length, length_saturated, output ready);
endinterface

[rtl/pla_queue.sv]
// Small register queue that decouples the front end from the back end.
// Depends on pla_pkg for its depth.
module pla_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int DEPTH = pla_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/pla_front.sv]
// Front end: accept route points, hold the previous point, form |dx| and |dy|.
// Depends on pla_pkg (job control type) and pla_if (input channel).
module pla_front #(
  parameter int COORD_WIDTH = pla_pkg::COORD_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  pla_in_if.sink                    in_pt,
  input  logic                      q_full,
  output logic                      q_push,
  output logic [COORD_WIDTH-1:0]    job_ax,
  output logic [COORD_WIDTH-1:0]    job_ay,
  output pla_pkg::pla_job_ctrl_t    job_ctrl
);

  localparam int W = COORD_WIDTH;

  logic signed [W-1:0] prev_x_r, prev_y_r;
  logic                have_prev_r, have_prev_nxt;
  logic signed [W-1:0] cur_x, cur_y;
  logic signed [W:0]   dx, dy;
  logic [W:0]          mag_x, mag_y;
  logic                accept;

  assign in_pt.ready = !q_full;
  assign accept      = in_pt.valid && !q_full;
  assign q_push      = accept;

  // Only the low COORD_WIDTH bits count, as a two's complement value.
  assign cur_x = in_pt.longitude[W-1:0];
  assign cur_y = in_pt.latitude[W-1:0];

  assign dx    = {cur_x[W-1], cur_x} - {prev_x_r[W-1], prev_x_r};
  assign dy    = {cur_y[W-1], cur_y} - {prev_y_r[W-1], prev_y_r};
  assign mag_x = dx[W] ? (W+1)'(-dx) : dx;
  assign mag_y = dy[W] ? (W+1)'(-dy) : dy;

  // A difference of two W-bit values has a magnitude below 2^W.
  assign job_ax           = mag_x[W-1:0];
  assign job_ay           = mag_y[W-1:0];
  assign job_ctrl.has_seg = have_prev_r;
  assign job_ctrl.last    = in_pt.last_point;

  always_comb begin
    have_prev_nxt = have_prev_r;
    if (accept) begin
      have_prev_nxt = !in_pt.last_point;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
    end else begin
      have_prev_r <= have_prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_x_r <= cur_x;
      prev_y_r <= cur_y;
    end
  end

endmodule

[rtl/pla_back.sv]
// Back end: square, sum, bit-serial integer root, saturating accumulate, result register.
// Depends on pla_pkg (state and job types) and pla_if (result channel).
module pla_back #(
  parameter int COORD_WIDTH = pla_pkg::COORD_WIDTH_DEF,
  parameter int ACC_WIDTH   = pla_pkg::ACC_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_not_empty,
  output logic                      q_pop,
  input  logic [COORD_WIDTH-1:0]    job_ax,
  input  logic [COORD_WIDTH-1:0]    job_ay,
  input  pla_pkg::pla_job_ctrl_t    job_ctrl,
  pla_out_if.source                 out_res
);

  localparam int W    = COORD_WIDTH;
  localparam int RW   = W + 1;            // root bits
  localparam int NW   = 2 * RW;           // radicand bits, padded to even
  localparam int CTW  = $clog2(RW + 1);
  localparam int LW   = pla_pkg::OUT_LEN_W;

  pla_pkg::pla_bk_state_t st_r, st_nxt;

  logic [W-1:0]           ax_r, ay_r;
  pla_pkg::pla_job_ctrl_t ctrl_r;
  logic [2*W-1:0]         sx_r, sy_r;
  logic [NW-1:0]          rad_r;
  logic [RW+1:0]          rem_r;
  logic [RW-1:0]          root_r;
  logic [CTW-1:0]         cnt_r;
  logic [ACC_WIDTH-1:0]   total_r;
  logic                   sat_r;
  logic                   out_valid_r;
  logic [LW-1:0]          out_len_r;
  logic                   out_sat_r;

  // Sequencer strobes.
  logic do_take, do_sqr, do_sum, do_step, do_acc, root_done, out_blocked;

  logic [RW+1:0]          rem_sh, trial;
  logic [ACC_WIDTH:0]     acc_sum;
  logic [ACC_WIDTH-1:0]   total_new;
  logic                   sat_new;
  logic [ACC_WIDTH+LW-1:0] total_wide;

  assign root_done   = (cnt_r == CTW'(RW - 1));
  assign out_blocked = out_valid_r && !out_res.ready;

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      pla_pkg::BK_IDLE: begin
        if (q_not_empty) begin
          st_nxt = job_ctrl.has_seg ? pla_pkg::BK_SQR : pla_pkg::BK_ACC;
        end
      end
      pla_pkg::BK_SQR:  st_nxt = pla_pkg::BK_SUM;
      pla_pkg::BK_SUM:  st_nxt = pla_pkg::BK_ROOT;
      pla_pkg::BK_ROOT: begin
        if (root_done) begin
          st_nxt = pla_pkg::BK_ACC;
        end
      end
      pla_pkg::BK_ACC: begin
        if (!(ctrl_r.last && out_blocked)) begin
          st_nxt = pla_pkg::BK_IDLE;
        end
      end
      default: st_nxt = pla_pkg::BK_IDLE;
    endcase
  end

  // Strobes.
  always_comb begin
    do_take = 1'b0;
    do_sqr  = 1'b0;
    do_sum  = 1'b0;
    do_step = 1'b0;
    do_acc  = 1'b0;
    unique case (st_r)
      pla_pkg::BK_IDLE: do_take = q_not_empty;
      pla_pkg::BK_SQR:  do_sqr  = 1'b1;
      pla_pkg::BK_SUM:  do_sum  = 1'b1;
      pla_pkg::BK_ROOT: do_step = 1'b1;
      pla_pkg::BK_ACC:  do_acc  = !(ctrl_r.last && out_blocked);
      default: ;
    endcase
  end

  assign q_pop = do_take;

  // One root digit per cycle: bring down two radicand bits, try 4r+1.
  assign rem_sh = {rem_r[RW-1:0], rad_r[NW-1 -: 2]};
  assign trial  = {root_r, 2'b01};

  // Saturating add of the segment length.
  assign acc_sum = {1'b0, total_r} + (ACC_WIDTH+1)'(root_r);
  always_comb begin
    total_new = total_r;
    sat_new   = sat_r;
    if (ctrl_r.has_seg) begin
      if (acc_sum[ACC_WIDTH]) begin
        total_new = '1;
        sat_new   = 1'b1;
      end else begin
        total_new = acc_sum[ACC_WIDTH-1:0];
      end
    end
  end

  // Keep the low result bits, zero-extending a narrow total.
  assign total_wide = {LW'(0), total_new};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= pla_pkg::BK_IDLE;
      total_r     <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      st_r <= st_nxt;
      // A new result may replace one that is taken at the same edge.
      if (do_acc && ctrl_r.last) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_res.ready) begin
        out_valid_r <= 1'b0;
      end
      if (do_sum) begin
        cnt_r <= '0;
      end else if (do_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (do_acc) begin
        if (ctrl_r.last) begin
          total_r <= '0;
          sat_r   <= 1'b0;
        end else begin
          total_r <= total_new;
          sat_r   <= sat_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_take) begin
      ax_r   <= job_ax;
      ay_r   <= job_ay;
      ctrl_r <= job_ctrl;
    end
    if (do_sqr) begin
      sx_r <= (2*W)'(ax_r) * (2*W)'(ax_r);
      sy_r <= (2*W)'(ay_r) * (2*W)'(ay_r);
    end
    if (do_sum) begin
      rad_r  <= {1'b0, ({1'b0, sx_r} + {1'b0, sy_r})};
      rem_r  <= '0;
      root_r <= '0;
    end
    if (do_step) begin
      rad_r <= rad_r << 2;
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[RW-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[RW-2:0], 1'b0};
      end
    end
    if (do_acc && ctrl_r.last) begin
      out_len_r <= total_wide[LW-1:0];
      out_sat_r <= sat_new;
    end
  end

  assign out_res.valid            = out_valid_r;
  assign out_res.route_length     = out_len_r;
  assign out_res.length_saturated = out_sat_r;

endmodule

[rtl/polyline_length_accumulator_core.sv]
// Top level of the polyline length accumulator.
// Depends on pla_pkg, pla_if, pla_front, pla_queue and pla_back.
//
// Route points arrive on in_pt as signed fixed-point longitude/latitude pairs;
// only the low COORD_WIDTH bits of each coordinate are used. For every point
// after the first of a route the block adds floor(sqrt(dx^2 + dy^2)) to a
// running total of ACC_WIDTH bits, which clamps at its maximum and then sets a
// sticky saturation flag. On a point marked last_point one result leaves on
// out_res (the total, low 48 bits, and the flag) and the route state clears;
// a route of a single point reports zero. A point that closes a segment
// takes the back end through the idle, square, sum, root and accumulate
// states; the root produces one result bit per cycle. The first point of a
// route goes from idle straight to accumulate. A two-entry queue lets the
// front end take points while the back end is busy, and the result register
// lets the next route proceed while a result waits to be taken.
module polyline_length_accumulator_core #(
  parameter int COORD_WIDTH = pla_pkg::COORD_WIDTH_DEF,
  parameter int ACC_WIDTH   = pla_pkg::ACC_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pla_in_if.sink     in_pt,
  pla_out_if.source  out_res
);

  localparam int JOB_W = 2 * COORD_WIDTH + $bits(pla_pkg::pla_job_ctrl_t);

  // Front-to-queue job.
  logic                   q_push, q_full;
  logic [COORD_WIDTH-1:0] f_ax, f_ay;
  pla_pkg::pla_job_ctrl_t f_ctrl;

  // Queue-to-back job.
  logic                   q_pop, q_not_empty;
  logic [JOB_W-1:0]       q_data;
  logic [COORD_WIDTH-1:0] b_ax, b_ay;
  pla_pkg::pla_job_ctrl_t b_ctrl;

  // Accept points and form absolute coordinate differences.
  pla_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pt    (in_pt),
    .q_full   (q_full),
    .q_push   (q_push),
    .job_ax   (f_ax),
    .job_ay   (f_ay),
    .job_ctrl (f_ctrl)
  );

  // Hold pending jobs so each side can stall on its own.
  pla_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_ctrl, f_ay, f_ax}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  assign b_ax   = q_data[COORD_WIDTH-1:0];
  assign b_ay   = q_data[2*COORD_WIDTH-1:COORD_WIDTH];
  assign b_ctrl = q_data[JOB_W-1:2*COORD_WIDTH];

  // Measure segments, accumulate and present results.
  pla_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .ACC_WIDTH   (ACC_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_pop       (q_pop),
    .job_ax      (b_ax),
    .job_ay      (b_ay),
    .job_ctrl    (b_ctrl),
    .out_res     (out_res)
  );

endmodule
